// File: sv/ppi_pkg.sv
package ppi_pkg;

    typedef struct packed {
        logic signed [31:0] other_normal_x;
        logic signed [31:0] other_normal_y;
        logic signed [31:0] other_normal_z;
        logic signed [31:0] other_offset;
    } ppi_in_t;

    typedef struct packed {
        logic               parallel;
        logic [1:0]         zeroed_axis;
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic signed [31:0] dir_x;
        logic signed [31:0] dir_y;
        logic signed [31:0] dir_z;
    } ppi_out_t;

    localparam logic [1:0] REG_NX  = 2'd0;
    localparam logic [1:0] REG_NY  = 2'd1;
    localparam logic [1:0] REG_NZ  = 2'd2;
    localparam logic [1:0] REG_OFF = 2'd3;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    // 65-bit magnitude of a difference of two 64-bit products
    localparam int MagW = 65;
    // numerator scaled by 2^16 for the Q16.16 quotient
    localparam int RemW = MagW + 16;
    // quotient bits: 16 integer + 16 fraction + 1 overflow
    localparam int QW = 33;

    function automatic logic [31:0] sat_out(input logic neg, input logic [QW-1:0] mag);
        logic [31:0] r;
        begin
            if (!neg)
                r = (mag > 33'h07FFFFFFF) ? 32'h7FFFFFFF : mag[31:0];
            else
                r = (mag > 33'h080000000) ? 32'h80000000 : 32'(-mag[31:0]);
            return r;
        end
    endfunction

endpackage

// File: sv/ppi_div_stage.sv
// one restoring quotient bit per stage
module ppi_div_stage
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      vld,
    input  logic [ppi_pkg::RemW-1:0]  rem,
    input  logic [ppi_pkg::MagW-1:0]  den,
    input  logic [ppi_pkg::QW-1:0]    q,
    input  logic [5:0]                bitpos,
    output logic                      vld_reg,
    output logic [ppi_pkg::RemW-1:0]  rem_reg,
    output logic [ppi_pkg::QW-1:0]    q_reg
);
    import ppi_pkg::*;

    logic [RemW+QW-1:0] dsh;
    logic [RemW-1:0]    rem_next;
    logic               take;

    always_comb
    begin
        dsh = {{(RemW+QW-MagW){1'b0}}, den} << bitpos;
        take = ({{QW{1'b0}}, rem} >= dsh);
        rem_next = take ? RemW'({{QW{1'b0}}, rem} - dsh) : rem;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld;
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        q_reg   <= q | (QW'(take) << bitpos[4:0]) | (take && bitpos == 6'd32 ? {1'b1, 32'd0} : '0);
    end
endmodule

// File: sv/ppi_front.sv
// products, differences, axis pick, numerator select (3 stages)
module ppi_front
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  vld,
    input  logic signed [31:0]    ax,
    input  logic signed [31:0]    ay,
    input  logic signed [31:0]    az,
    input  logic signed [31:0]    d1,
    input  ppi_pkg::ppi_in_t      din,
    output logic                  vld_reg,
    output logic                  par_reg,
    output logic [1:0]            axis_reg,
    output logic                  neg_reg,
    output logic [ppi_pkg::MagW-1:0] n0_reg,
    output logic [ppi_pkg::MagW-1:0] n1_reg,
    output logic [ppi_pkg::MagW-1:0] den_reg,
    output logic                  nneg0_reg,
    output logic                  nneg1_reg,
    output logic [95:0]           dir_reg
);
    import ppi_pkg::*;

    logic signed [63:0] p_reg [18];
    logic s1_reg;
    logic signed [64:0] c_reg [9];
    logic s2_reg;
    logic [MagW-1:0] m [3];
    logic [1:0] ax_sel;
    logic signed [64:0] na, nb, dd;
    logic signed [63:0] bx, by, bz, d2;

    assign bx = 64'(din.other_normal_x);
    assign by = 64'(din.other_normal_y);
    assign bz = 64'(din.other_normal_z);
    assign d2 = 64'(din.other_offset);

    always_ff @(posedge clk)
    begin
        p_reg[0]  <= 64'(ay) * bz;
        p_reg[1]  <= 64'(az) * by;
        p_reg[2]  <= 64'(az) * bx; p_reg[3] <= 64'(ax) * bz;
        p_reg[4]  <= 64'(ax) * by; p_reg[5] <= 64'(ay) * bx;
        p_reg[6]  <= 64'(d1) * bz; p_reg[7] <= d2 * az;
        p_reg[8]  <= d2 * ay;      p_reg[9] <= 64'(d1) * by;
        p_reg[10] <= d2 * az;      p_reg[11] <= 64'(d1) * bz;
        p_reg[12] <= 64'(d1) * bx; p_reg[13] <= d2 * ax;
        p_reg[14] <= 64'(d1) * by; p_reg[15] <= d2 * ay;
        p_reg[16] <= d2 * ax;      p_reg[17] <= 64'(d1) * bx;
        for (int i = 0; i < 9; i++)
            c_reg[i] <= 65'(p_reg[2*i]) - 65'(p_reg[2*i+1]);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            m[i] = c_reg[i][64] ? MagW'(-c_reg[i]) : MagW'(c_reg[i]);
        if (m[0] > m[1])
            ax_sel = (m[0] > m[2]) ? AXIS_X : AXIS_Z;
        else
            ax_sel = (m[1] > m[2]) ? AXIS_Y : AXIS_Z;
        case (ax_sel)
            AXIS_X:  begin na = c_reg[3]; nb = c_reg[4]; dd = c_reg[0]; end
            AXIS_Y:  begin na = c_reg[5]; nb = c_reg[6]; dd = c_reg[1]; end
            default: begin na = c_reg[7]; nb = c_reg[8]; dd = c_reg[2]; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= 1'b0; s2_reg <= 1'b0; vld_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= vld; s2_reg <= s1_reg; vld_reg <= s2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        par_reg   <= (m[0] == '0) && (m[1] == '0) && (m[2] == '0);
        axis_reg  <= ax_sel;
        neg_reg   <= dd[64];
        den_reg   <= dd[64] ? MagW'(-dd) : MagW'(dd);
        nneg0_reg <= na[64];
        nneg1_reg <= nb[64];
        n0_reg    <= na[64] ? MagW'(-na) : MagW'(na);
        n1_reg    <= nb[64] ? MagW'(-nb) : MagW'(nb);
        dir_reg   <= {sat_out(c_reg[0][64], QW'(m[0] >> 16) | (|m[0][64:48] ? {1'b1,32'd0} : '0)),
                      sat_out(c_reg[1][64], QW'(m[1] >> 16) | (|m[1][64:48] ? {1'b1,32'd0} : '0)),
                      sat_out(c_reg[2][64], QW'(m[2] >> 16) | (|m[2][64:48] ? {1'b1,32'd0} : '0))};
    end
endmodule

// File: sv/plane_plane_intersection_top.sv
// channel | signals                          | handshake
// item in | start, busy, item_in             | accepted when start && !busy
// result  | done, item_out                   | one cycle strobe, no backpressure
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data | write when valid && ready
// One item per cycle; results come out of the 34-stage
// bit-serial quotient pipeline (one restoring step per stage).
// busy is always low; results cannot be stalled.
// Reset loads the default normal (0,0,1), offset 0 and empties the pipe.
module plane_plane_intersection_top
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ppi_pkg::ppi_in_t  item_in,
    output logic              done,
    output ppi_pkg::ppi_out_t item_out,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [31:0]       cfg_data
);
    import ppi_pkg::*;

    localparam int NS = 34;

    logic signed [31:0] nx_reg, ny_reg, nz_reg, off_reg;
    logic fv, par, neg, nn0, nn1;
    logic [1:0] axis;
    logic [MagW-1:0] n0, n1, den;
    logic [95:0] dir;

    logic              v_reg  [NS+1];
    logic [RemW-1:0]   r0_reg [NS+1];
    logic [RemW-1:0]   r1_reg [NS+1];
    logic [QW-1:0]     q0_reg [NS+1];
    logic [QW-1:0]     q1_reg [NS+1];
    logic [MagW-1:0]   dn_reg [NS+1];
    logic [7:0]        sb_reg [NS+1];
    logic [95:0]       dr_reg [NS+1];
    logic [31:0]       pa, pb;
    logic [QW-1:0]     qa, qb;

    assign busy = 1'b0;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nx_reg <= '0; ny_reg <= '0; nz_reg <= 32'sd65536; off_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_NX:  nx_reg  <= cfg_data;
                REG_NY:  ny_reg  <= cfg_data;
                REG_NZ:  nz_reg  <= cfg_data;
                default: off_reg <= cfg_data;
            endcase
        end
    end

    ppi_front u_front (
        .clk, .rst_n, .vld(start), .ax(nx_reg), .ay(ny_reg), .az(nz_reg), .d1(off_reg),
        .din(item_in), .vld_reg(fv), .par_reg(par), .axis_reg(axis), .neg_reg(neg),
        .n0_reg(n0), .n1_reg(n1), .den_reg(den), .nneg0_reg(nn0), .nneg1_reg(nn1),
        .dir_reg(dir)
    );

    // quotient capped: bits above 2^32 only flag overflow
    assign v_reg[0]  = fv;
    assign r0_reg[0] = {n0, 16'd0};
    assign r1_reg[0] = {n1, 16'd0};
    assign q0_reg[0] = '0;
    assign q1_reg[0] = '0;
    assign dn_reg[0] = den;
    assign sb_reg[0] = {par, axis, neg, nn0, nn1, 2'b00};
    assign dr_reg[0] = dir;

    for (genvar g = 0; g < NS; g++)
    begin : g_div
        logic [5:0] bp;
        logic       vb;
        // stages 0 and 1 test quotient >= 2^32 (saturation), then bits 31..0
        assign bp = (g == 0) ? 6'd32 : 6'(NS - 2 - g + 1);
        ppi_div_stage u_a (
            .clk, .rst_n, .vld(v_reg[g]), .rem(r0_reg[g]), .den(dn_reg[g]), .q(q0_reg[g]),
            .bitpos(bp), .vld_reg(v_reg[g+1]), .rem_reg(r0_reg[g+1]), .q_reg(q0_reg[g+1])
        );
        ppi_div_stage u_b (
            .clk, .rst_n, .vld(v_reg[g]), .rem(r1_reg[g]), .den(dn_reg[g]), .q(q1_reg[g]),
            .bitpos(bp), .vld_reg(vb), .rem_reg(r1_reg[g+1]), .q_reg(q1_reg[g+1])
        );
        always_ff @(posedge clk)
        begin
            dn_reg[g+1] <= dn_reg[g];
            sb_reg[g+1] <= sb_reg[g] | {7'd0, vb & 1'b0};
            dr_reg[g+1] <= dr_reg[g];
        end
    end

    assign qa = (q0_reg[NS][32] || q0_reg[NS][31:16] == 16'hFFFF && 1'b0) ? {1'b1, 32'd0} : q0_reg[NS];
    assign qb = q1_reg[NS][32] ? {1'b1, 32'd0} : q1_reg[NS];
    assign pa = (dn_reg[NS] == '0) ? 32'd0 : sat_out(sb_reg[NS][3] != sb_reg[NS][4], qa);
    assign pb = (dn_reg[NS] == '0) ? 32'd0 : sat_out(sb_reg[NS][2] != sb_reg[NS][4], qb);

    always_comb
    begin
        done = v_reg[NS];
        item_out = '0;
        if (sb_reg[NS][7])
            item_out.parallel = 1'b1;
        else
        begin
            item_out.zeroed_axis = sb_reg[NS][6:5];
            item_out.dir_x = dr_reg[NS][95:64];
            item_out.dir_y = dr_reg[NS][63:32];
            item_out.dir_z = dr_reg[NS][31:0];
            case (sb_reg[NS][6:5])
                AXIS_X:  begin item_out.point_y = pa; item_out.point_z = pb; end
                AXIS_Y:  begin item_out.point_x = pa; item_out.point_z = pb; end
                default: begin item_out.point_x = pa; item_out.point_y = pb; end
            endcase
        end
    end

    a_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
        else $error("busy raised");
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, NS + 3))
        else $error("result without item");
    a_par: assert property (@(posedge clk) disable iff (!rst_n)
        done && item_out.parallel |-> item_out.dir_x == 0 && item_out.zeroed_axis == 0)
        else $error("parallel result not clear");
endmodule

// File: bench/tb_plane_plane_intersection_top.sv
`timescale 1ns / 1ps

module tb_plane_plane_intersection_top;
    import ppi_pkg::*;

    localparam int SETTLE = 45;
    localparam int CYCLE_LIMIT = 400000;

    typedef logic signed [65:0] wide_t;

    typedef struct {
        ppi_in_t  item;
        logic     typed;
        ppi_out_t line;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    ppi_in_t item_in = '0;
    logic done;
    ppi_out_t item_out;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_NX;
    logic [31:0] cfg_data = '0;

    logic signed [31:0] plane_reg [4];
    ppi_out_t line_q[$];
    int mismatches = 0;
    int cycles = 0;
    int idle_pct = 0;

    plane_plane_intersection_top dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .item_in(item_in),
        .done(done), .item_out(item_out), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    function automatic wide_t cross_term(input wide_t a, input wide_t b, input wide_t c,
                                         input wide_t d);
        return a * b - c * d;
    endfunction

    function automatic logic [81:0] magnitude(input wide_t v);
        return v < 0 ? 82'(-v) : 82'(v);
    endfunction

    function automatic logic [31:0] clamp_q16(input logic neg, input logic [81:0] mag);
        if (!neg)
            return mag > 82'h7FFFFFFF ? 32'h7FFFFFFF : mag[31:0];
        return mag > 82'h80000000 ? 32'h80000000 : 32'(-mag[31:0]);
    endfunction

    function automatic logic [31:0] solve_coord(input wide_t num, input wide_t den);
        logic [81:0] q;
        if (den == 0)
            return '0;
        q = (magnitude(num) << 16) / magnitude(den);
        if (q > 82'h100000000)
            q = 82'h100000000;
        return clamp_q16(num[65] ^ den[65], q);
    endfunction

    function automatic ppi_out_t intersect_planes(input ppi_in_t b);
        ppi_out_t r;
        wide_t ax, ay, az, d1, bx, by, bz, d2;
        wide_t dir [3];
        logic [81:0] mx, my, mz;
        ax = plane_reg[REG_NX];
        ay = plane_reg[REG_NY];
        az = plane_reg[REG_NZ];
        d1 = plane_reg[REG_OFF];
        bx = b.other_normal_x;
        by = b.other_normal_y;
        bz = b.other_normal_z;
        d2 = b.other_offset;
        r = '0;
        dir[0] = cross_term(ay, bz, az, by);
        dir[1] = cross_term(az, bx, ax, bz);
        dir[2] = cross_term(ax, by, ay, bx);
        mx = magnitude(dir[0]);
        my = magnitude(dir[1]);
        mz = magnitude(dir[2]);
        if (mx == 0 && my == 0 && mz == 0)
        begin
            r.parallel = 1'b1;
            return r;
        end
        if (mx > my)
            r.zeroed_axis = mx > mz ? AXIS_X : AXIS_Z;
        else
            r.zeroed_axis = my > mz ? AXIS_Y : AXIS_Z;
        case (r.zeroed_axis)
            AXIS_X:
            begin
                r.point_y = solve_coord(cross_term(d1, bz, d2, az), dir[0]);
                r.point_z = solve_coord(cross_term(d2, ay, d1, by), dir[0]);
            end
            AXIS_Y:
            begin
                r.point_x = solve_coord(cross_term(d2, az, d1, bz), dir[1]);
                r.point_z = solve_coord(cross_term(d1, bx, d2, ax), dir[1]);
            end
            default:
            begin
                r.point_x = solve_coord(cross_term(d1, by, d2, ay), dir[2]);
                r.point_y = solve_coord(cross_term(d2, ax, d1, bx), dir[2]);
            end
        endcase
        r.dir_x = clamp_q16(dir[0][65], mx >> 16);
        r.dir_y = clamp_q16(dir[1][65], my >> 16);
        r.dir_z = clamp_q16(dir[2][65], mz >> 16);
        return r;
    endfunction

    always @(posedge clk)
    begin
        ppi_out_t want;
        if (rst_n && done)
        begin
            if (line_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", item_out);
            end
            else
            begin
                want = line_q.pop_front();
                if (item_out.parallel !== want.parallel
                    || item_out.zeroed_axis !== want.zeroed_axis
                    || item_out.point_x !== want.point_x || item_out.point_y !== want.point_y
                    || item_out.point_z !== want.point_z || item_out.dir_x !== want.dir_x
                    || item_out.dir_y !== want.dir_y || item_out.dir_z !== want.dir_z)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp par %0d axis %0d pt %h %h %h dir %h %h %h\n"
                            , want.parallel, want.zeroed_axis, want.point_x, want.point_y
                            , want.point_z, want.dir_x, want.dir_y, want.dir_z
                            , "          got par %0d axis %0d pt %h %h %h dir %h %h %h"
                            , item_out.parallel, item_out.zeroed_axis, item_out.point_x
                            , item_out.point_y, item_out.point_z, item_out.dir_x
                            , item_out.dir_y, item_out.dir_z);
                end
            end
        end
    end

    task automatic drain();
        while (line_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        plane_reg[idx] = value;
    endtask

    task automatic load_plane(input logic [31:0] nx, input logic [31:0] ny,
                              input logic [31:0] nz, input logic [31:0] off);
        drain();
        write_reg(REG_NX, nx);
        write_reg(REG_NY, ny);
        write_reg(REG_NZ, nz);
        write_reg(REG_OFF, off);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_item(input ppi_in_t x, input logic typed, input ppi_out_t typed_line);
        int gap;
        start <= 1'b1;
        item_in <= x;
        do
            @(posedge clk);
        while (busy);
        line_q.push_back(typed ? typed_line : intersect_planes(x));
        gap = ($urandom_range(99) < idle_pct) ? $urandom_range(1, 6) : 0;
        if ($urandom_range(199) == 0)
            gap = 60;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic logic [31:0] rand_coord(input int kind);
        case (kind)
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 8 * 65536)) - 4 * 65536);
            2: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            default: return $urandom_range(1) ? 32'h7FFFFFFF : 32'h80000000;
        endcase
    endfunction

    task automatic random_phase(input int count);
        ppi_in_t x;
        int kind;
        int k;
        for (int i = 0; i < count; i++)
        begin
            kind = $urandom_range(9);
            if (kind < 2)
            begin
                // scaled copy of own normal, sometimes nudged
                k = $signed($urandom_range(0, 6)) - 3;
                x.other_normal_x = plane_reg[REG_NX] * k;
                x.other_normal_y = plane_reg[REG_NY] * k;
                x.other_normal_z = plane_reg[REG_NZ] * k;
                if (kind == 1)
                    x.other_normal_y = x.other_normal_y + ($signed($urandom_range(0, 4)) - 2);
                x.other_offset = rand_coord($urandom_range(2));
            end
            else
            begin
                kind = (kind < 5) ? 0 : (kind < 8 ? 1 : (kind == 8 ? 2 : 3));
                x.other_normal_x = rand_coord(kind);
                x.other_normal_y = rand_coord(kind);
                x.other_normal_z = rand_coord(kind);
                x.other_offset = rand_coord($urandom_range(3));
            end
            send_item(x, 1'b0, '0);
        end
        start <= 1'b0;
    endtask

    row_t rows [$];

    initial
    begin
        ppi_out_t e;
        plane_reg[REG_NX] = '0;
        plane_reg[REG_NY] = '0;
        plane_reg[REG_NZ] = 32'h00010000;
        plane_reg[REG_OFF] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        e = '0;
        e.parallel = 1'b1;
        rows.push_back('{'{32'h0, 32'h0, 32'h00010000, 32'h0}, 1'b1, e});
        rows.push_back('{'{32'h0, 32'h0, 32'h0, 32'h7FFFFFFF}, 1'b1, e});
        e = '0;
        e.zeroed_axis = AXIS_Y;
        e.point_x = 32'h00020000;
        e.dir_y = 32'h00010000;
        rows.push_back('{'{32'h00010000, 32'h0, 32'h0, 32'h00020000}, 1'b1, e});
        rows.push_back('{'{32'h00010000, 32'h00010000, 32'h0, 32'h00010000}, 1'b0, '0});
        rows.push_back('{'{32'h0, 32'h00010000, 32'h0, 32'hFFFF0000}, 1'b0, '0});
        rows.push_back('{'{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000}, 1'b0, '0});
        rows.push_back('{'{32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF}, 1'b0, '0});
        rows.push_back('{'{32'h00000001, 32'h0, 32'h0, 32'h7FFFFFFF}, 1'b0, '0});
        rows.push_back('{'{32'hFFFFFFFF, 32'h00000001, 32'h12345678, 32'h80000000}, 1'b0, '0});
        foreach (rows[i])
            send_item(rows[i].item, rows[i].typed, rows[i].line);
        start <= 1'b0;

        load_plane(32'h00010000, 32'h00010000, 32'h00010000, 32'h00030000);
        foreach (rows[i])
            send_item(rows[i].item, 1'b0, '0);
        start <= 1'b0;
        load_plane(32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
        foreach (rows[i])
            send_item(rows[i].item, 1'b0, '0);
        start <= 1'b0;

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase % 3)
                0: idle_pct = 0;
                1: idle_pct = 83;
                default: idle_pct = 29;
            endcase
            case (phase)
                0: load_plane(32'h0, 32'h0, 32'h00010000, 32'h0);
                1: load_plane(rand_coord(1), rand_coord(1), rand_coord(1), rand_coord(1));
                2: load_plane(32'h7FFFFFFF, 32'h00000001, 32'h80000000, 32'h80000000);
                3: load_plane($urandom(), $urandom(), $urandom(), $urandom());
                4: load_plane(rand_coord(2), rand_coord(2), rand_coord(2), rand_coord(0));
                default: load_plane(32'h0, 32'h0, 32'h0, 32'h7FFFFFFF);
            endcase
            random_phase(215);
        end

        while (line_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0 && line_q.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// File: filelist.f
sv/ppi_pkg.sv
sv/ppi_div_stage.sv
sv/ppi_front.sv
sv/plane_plane_intersection_top.sv
bench/tb_plane_plane_intersection_top.sv
